// File: sv/overwrite_ring_fifo_macros.svh
// Assertion macros shared by the overwrite ring FIFO modules.
`ifndef OVERWRITE_RING_FIFO_MACROS_SVH
`define OVERWRITE_RING_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ORF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ORF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/orf_pkg.sv
// Types, constants and helpers shared by the overwrite ring FIFO modules.
package orf_pkg;

  localparam int RingDepth = 256;
  localparam int PtrW      = $clog2(RingDepth);
  localparam int CntW      = $clog2(RingDepth + 1);
  localparam int CapW      = 9;
  localparam int DataW     = 8;
  localparam int OpW       = 2;

  localparam logic [CapW-1:0] CapReset = 9'd256;

  // Request operation codes.
  localparam logic [OpW-1:0] OpWrite = 2'd0;
  localparam logic [OpW-1:0] OpRead  = 2'd1;
  localparam logic [OpW-1:0] OpFlush = 2'd2;
  localparam logic [OpW-1:0] OpClrOv = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] data_out;
    logic             data_valid;
    logic [CapW-1:0]  fill_length;
    logic             overflow_seen;
    logic             became_nonempty;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // a request is accepted this cycle
    logic wr;       // store the byte
    logic rd;       // remove the oldest byte
    logic flush;    // empty the ring
    logic clr_ov;   // clear the sticky overflow flag
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

  // Capacity in use: zero acts as one, large values clamp to the store depth.
  function automatic logic [CntW-1:0] eff_cap(input logic [CapW-1:0] c);
    logic [CntW-1:0] r;
    if (c == '0) begin
      r = CntW'(1);
    end else if (32'(c) > RingDepth) begin
      r = CntW'(RingDepth);
    end else begin
      r = CntW'(c);
    end
    return r;
  endfunction

endpackage

// File: sv/overwrite_ring_fifo.sv
// Latency: a request accepted at a clock edge has its result on rsp_o, with
// strobe_o high, for the single cycle that follows; data comes from a registered store read.
// Throughput: one request per cycle, since pointer and count updates are registered each cycle.
// busy stays low and the result receiver cannot stall.
// Reset: empty ring, capacity 256, overflow flag clear; store contents undefined until written.
module overwrite_ring_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  orf_pkg::req_t             req_i,
  output orf_pkg::rsp_t             rsp_o,
  output logic                      strobe_o,
  input  logic                      cfg_we_i,
  input  logic [orf_pkg::CapW-1:0]  cfg_wdata_i
);
  import orf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Request decode and result timing.
  orf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .strobe_o (strobe_o)
  );

  // Ring state and byte store.
  orf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .data_i      (req_i.data_in),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

endmodule

// File: sv/orf_ctrl.sv
// Controller of the overwrite ring FIFO: request decode and result timing.
`include "overwrite_ring_fifo_macros.svh"
module orf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  orf_pkg::req_t req_i,
  input  orf_pkg::stat_t stat_i,
  output orf_pkg::cmd_t cmd_o,
  output logic          strobe_o
);
  import orf_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StResp = 1'b1;

  logic state_q, state_d;
  logic accept;

  // No request ever stalls, so a new one is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the accepted request into datapath commands.
  always_comb begin
    cmd_o      = '0;
    cmd_o.take = accept;
    if (accept) begin
      unique case (req_i.op)
        OpWrite: cmd_o.wr     = 1'b1;
        OpRead:  cmd_o.rd     = !stat_i.empty;
        OpFlush: cmd_o.flush  = 1'b1;
        OpClrOv: cmd_o.clr_ov = 1'b1;
        default: cmd_o        = '0;
      endcase
    end
  end

  // The result of a request is shown in the cycle after it was accepted.
  always_comb begin
    unique case (state_q)
      StIdle:  state_d = accept ? StResp : StIdle;
      StResp:  state_d = accept ? StResp : StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign strobe_o = (state_q == StResp);

  // A read is never issued on an empty ring.
  `ORF_ASSERT_SAME(a_rd_not_empty, cmd_o.rd, !stat_i.empty, "read issued on empty ring")
  // Each accepted request yields a result strobe in the next cycle.
  `ORF_ASSERT_NEXT(a_strobe_follows, accept, strobe_o, "missing result strobe")
  // A full ring always holds at least one byte.
  `ORF_ASSERT_SAME(a_full_not_empty, stat_i.full, !stat_i.empty, "full ring reported empty")

endmodule

// File: sv/orf_datapath.sv
// Datapath of the overwrite ring FIFO: pointers, fill count, flag and byte store.
`include "overwrite_ring_fifo_macros.svh"
module orf_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [orf_pkg::CapW-1:0]   cfg_wdata_i,
  input  orf_pkg::cmd_t              cmd_i,
  input  logic [orf_pkg::DataW-1:0]  data_i,
  output orf_pkg::stat_t             stat_o,
  output orf_pkg::rsp_t              rsp_o
);
  import orf_pkg::*;

  logic [CapW-1:0]  cap_q;
  logic [PtrW-1:0]  rp_q, rp_d;
  logic [PtrW-1:0]  lw_q, lw_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ov_q, ov_d;
  logic [CntW-1:0]  cap_eff;
  logic [PtrW-1:0]  cap_m1;
  logic [PtrW-1:0]  rp_inc, lw_inc;
  logic             full;

  logic [DataW-1:0] mem_q [RingDepth];
  logic [DataW-1:0] rd_q;
  logic             rvalid_q;
  logic [CapW-1:0]  fill_q;
  logic             ovs_q;
  logic             nonempty_q;

  assign cap_eff = eff_cap(cap_q);
  assign cap_m1  = PtrW'(cap_eff - CntW'(1));
  assign full    = (cnt_q == cap_eff);

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = full;

  // Pointer advance with wrap at the capacity in use.
  assign rp_inc = (rp_q == cap_m1) ? '0 : rp_q + PtrW'(1);
  assign lw_inc = (lw_q == cap_m1) ? '0 : lw_q + PtrW'(1);

  // Next state of pointers, fill count and overflow flag.
  always_comb begin
    rp_d  = rp_q;
    lw_d  = lw_q;
    cnt_d = cnt_q;
    ov_d  = ov_q;
    if (cmd_i.wr) begin
      lw_d = lw_inc;
      if (full) begin
        ov_d = 1'b1;
        rp_d = rp_inc;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
    if (cmd_i.rd) begin
      rp_d  = rp_inc;
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.flush) begin
      rp_d  = '0;
      lw_d  = cap_m1;
      cnt_d = '0;
    end
    if (cmd_i.clr_ov) begin
      ov_d = 1'b0;
    end
  end

  // Control registers; a capacity write also empties the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      rp_q  <= '0;
      lw_q  <= PtrW'(eff_cap(CapReset) - CntW'(1));
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
      rp_q  <= '0;
      lw_q  <= PtrW'(eff_cap(cfg_wdata_i) - CntW'(1));
      cnt_q <= '0;
    end else begin
      rp_q  <= rp_d;
      lw_q  <= lw_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  // Byte store with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[lw_inc] <= data_i;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[rp_q];
    end
  end

  // Result fields captured when a request is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (cmd_i.take) begin
      rvalid_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      fill_q     <= CapW'(cnt_d);
      ovs_q      <= ov_q | (cmd_i.wr & full);
      nonempty_q <= cmd_i.wr & stat_o.empty;
    end
  end

  assign rsp_o.data_out        = rvalid_q ? rd_q : '0;
  assign rsp_o.data_valid      = rvalid_q;
  assign rsp_o.fill_length     = fill_q;
  assign rsp_o.overflow_seen   = ovs_q;
  assign rsp_o.became_nonempty = nonempty_q;

  // The fill count never passes the capacity in use.
  `ORF_ASSERT_SAME(a_cnt_le_cap, 1'b1, cnt_q <= cap_eff, "fill count above capacity")
  // The read pointer stays inside the ring.
  `ORF_ASSERT_SAME(a_rp_in_ring, 1'b1, CntW'(rp_q) < cap_eff, "read pointer outside ring")
  // A write to a full ring keeps the count and raises the flag.
  `ORF_ASSERT_NEXT(a_overwrite, cmd_i.wr && full && !cmd_i.rd && !cfg_we_i,
    $stable(cnt_q) && ov_q, "overwrite of oldest byte mishandled")

endmodule
